// ===== design/emsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emsm_pkg
// Shared types, constants and helpers for the case-insensitive address
// pattern search block.
// ----------------------------------------------------------------------------
package emsm_pkg;

  localparam int NEEDLE_MAX = 32;
  localparam int LEN_W      = $clog2(NEEDLE_MAX + 1);
  localparam int IDX_W      = $clog2(NEEDLE_MAX);

  typedef logic [1:0]                  func_t;
  typedef logic [1:0]                  status_t;
  typedef logic [LEN_W-1:0]            len_t;
  typedef logic [NEEDLE_MAX-1:0][7:0]  bytes_t;

  localparam func_t FUNC_CLEAR  = 2'd0;
  localparam func_t FUNC_APPEND = 2'd1;
  localparam func_t FUNC_HAY    = 2'd2;

  localparam status_t ST_NONE    = 2'd0;
  localparam status_t ST_FOUND   = 2'd1;
  localparam status_t ST_INVALID = 2'd2;

  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7a;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef struct packed {
    func_t      func;
    logic [7:0] data_byte;
    logic       last;
  } req_t;

  typedef struct packed {
    status_t status;
    logic    hit_now;
    logic    done_res;
  } rsp_t;

  typedef struct packed {
    len_t len;
    logic has_at;
    logic first_is_at;
    logic overflow;
  } pat_info_t;

  typedef struct packed {
    logic clear;
    logic append;
  } pat_ctrl_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctrl_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UP_A && c <= CH_UP_Z) r = c + CASE_OFS;
    return r;
  endfunction

  function automatic logic starts_address(input logic [7:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_0 && c <= CH_9) ||
           c == CH_DOT || c == CH_UNDER || c == CH_DASH;
  endfunction

  function automatic logic pattern_valid(input pat_info_t p);
    return p.has_at && !p.first_is_at && !p.overflow;
  endfunction

endpackage

// ===== design/emsm_pattern.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emsm_pattern
// Pattern shift line and pattern flags. The newest byte sits at the top
// entry so the pattern stays aligned with the end of the search window.
// ----------------------------------------------------------------------------
module emsm_pattern (
  input  logic                 clk,
  input  logic                 rst,
  input  emsm_pkg::pat_ctrl_t  ctrl,
  input  logic [7:0]           byte_in,
  output emsm_pkg::bytes_t     pat,
  output emsm_pkg::pat_info_t  info,
  output emsm_pkg::pat_info_t  info_next
);

  logic room;

  assign room = info.len < emsm_pkg::LEN_W'(emsm_pkg::NEEDLE_MAX);

  always_comb begin
    info_next = info;
    if (ctrl.clear) begin
      info_next = '0;
    end else if (ctrl.append) begin
      if (room) begin
        if (byte_in == emsm_pkg::CH_AT) begin
          if (info.len == '0) info_next.first_is_at = 1'b1;
          info_next.has_at = 1'b1;
        end
        info_next.len = info.len + 1'b1;
      end else begin
        info_next.overflow = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      info <= '0;
    end else begin
      info <= info_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.append && !ctrl.clear && room) begin
      for (int j = 0; j < emsm_pkg::NEEDLE_MAX - 1; j++) pat[j] <= pat[j+1];
      pat[emsm_pkg::NEEDLE_MAX-1] <= byte_in;
    end
  end

endmodule

// ===== design/emsm_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emsm_window
// Haystack window of the most recent bytes with fill count, and the
// parallel masked compare against the end-aligned pattern.
// ----------------------------------------------------------------------------
module emsm_window (
  input  logic                 clk,
  input  logic                 rst,
  input  emsm_pkg::win_ctrl_t  ctrl,
  input  logic [7:0]           byte_in,
  input  emsm_pkg::bytes_t     pat,
  input  emsm_pkg::len_t       pat_len,
  output logic                 match
);

  emsm_pkg::bytes_t win;
  emsm_pkg::bytes_t win_next;
  emsm_pkg::len_t   fill;
  emsm_pkg::len_t   fill_next;
  emsm_pkg::len_t   start_full;
  logic [emsm_pkg::IDX_W-1:0] start_idx;
  logic             eq;

  always_comb begin
    for (int j = 0; j < emsm_pkg::NEEDLE_MAX - 1; j++) win_next[j] = win[j+1];
    win_next[emsm_pkg::NEEDLE_MAX-1] = byte_in;
    fill_next = (fill < emsm_pkg::LEN_W'(emsm_pkg::NEEDLE_MAX)) ? fill + 1'b1 : fill;
  end

  assign start_full = emsm_pkg::LEN_W'(emsm_pkg::NEEDLE_MAX) - pat_len;
  assign start_idx  = start_full[emsm_pkg::IDX_W-1:0];

  always_comb begin
    eq = fill_next >= pat_len;
    for (int j = 0; j < emsm_pkg::NEEDLE_MAX; j++) begin
      if (int'(pat_len) + j >= emsm_pkg::NEEDLE_MAX && win_next[j] != pat[j]) eq = 1'b0;
    end
  end

  assign match = eq && emsm_pkg::starts_address(win_next[start_idx]);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctrl.clear) begin
      fill <= '0;
    end else if (ctrl.shift) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      win <= win_next;
    end
  end

endmodule

// ===== design/email_address_substring_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// email_address_substring_matcher
// Case-insensitive search of a byte stream for an address pattern.
// Requests pass a request register and a response register; one request per
// cycle is taken unless the receiver stalls. The window compare is combinational.
// Reset clears pattern flags, pattern length, window fill and found flag.
// ----------------------------------------------------------------------------
module email_address_substring_matcher (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  emsm_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output emsm_pkg::rsp_t  rsp
);

  logic                 s1_valid;
  emsm_pkg::req_t       s1_req;
  logic                 advance;
  logic                 fire;
  logic [7:0]           c;
  logic                 is_clear;
  logic                 is_append;
  logic                 is_hay;
  logic                 found;
  logic                 found_next;
  logic                 found_mid;
  logic                 hit;
  logic                 match;
  emsm_pkg::rsp_t       rsp_next;
  emsm_pkg::pat_ctrl_t  pctrl;
  emsm_pkg::win_ctrl_t  wctrl;
  emsm_pkg::bytes_t     pat;
  emsm_pkg::pat_info_t  info;
  emsm_pkg::pat_info_t  info_next;

  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = s1_valid && !advance;
  assign fire      = s1_valid && advance;
  assign c         = emsm_pkg::fold(s1_req.data_byte);

  always_comb begin
    is_clear  = 1'b0;
    is_append = 1'b0;
    is_hay    = 1'b0;
    case (s1_req.func)
      emsm_pkg::FUNC_CLEAR:  is_clear  = 1'b1;
      emsm_pkg::FUNC_APPEND: is_append = 1'b1;
      emsm_pkg::FUNC_HAY:    is_hay    = 1'b1;
      default: ;
    endcase
  end

  assign pctrl.clear  = fire && is_clear;
  assign pctrl.append = fire && is_append;
  assign wctrl.shift  = fire && is_hay;
  assign wctrl.clear  = fire && (is_clear || (is_hay && s1_req.last));

  emsm_pattern u_pattern (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (pctrl),
    .byte_in   (c),
    .pat       (pat),
    .info      (info),
    .info_next (info_next)
  );

  emsm_window u_window (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (wctrl),
    .byte_in (c),
    .pat     (pat),
    .pat_len (info.len),
    .match   (match)
  );

  assign hit       = is_hay && emsm_pkg::pattern_valid(info) && match;
  assign found_mid = found || hit;

  always_comb begin
    rsp_next   = '0;
    found_next = found;
    if (is_hay) begin
      rsp_next.hit_now  = hit;
      rsp_next.done_res = s1_req.last;
      if (emsm_pkg::pattern_valid(info)) begin
        rsp_next.status = found_mid ? emsm_pkg::ST_FOUND : emsm_pkg::ST_NONE;
      end else begin
        rsp_next.status = emsm_pkg::ST_INVALID;
      end
      found_next = s1_req.last ? 1'b0 : found_mid;
    end else begin
      if (is_clear) found_next = 1'b0;
      if (emsm_pkg::pattern_valid(info_next)) begin
        rsp_next.status = found_next ? emsm_pkg::ST_FOUND : emsm_pkg::ST_NONE;
      end else begin
        rsp_next.status = emsm_pkg::ST_INVALID;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
      found     <= 1'b0;
    end else begin
      if (!s1_valid || advance) s1_valid <= req_valid;
      if (advance) rsp_valid <= s1_valid;
      if (fire) found <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!s1_valid || advance) s1_req <= req;
    if (fire) rsp <= rsp_next;
  end

endmodule

// ===== tb/sv/email_address_substring_matcher_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// email_address_substring_matcher_checker
// Watches the request and response channels of the address pattern matcher.
// Keeps its own copy of the pattern, the search window and the found flag,
// predicts one response per accepted request, and compares each accepted
// response field by field with the oldest prediction. Mismatches are counted
// and handed to the test top together with the number of open predictions.
// ----------------------------------------------------------------------------
module email_address_substring_matcher_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic            req_stall,
  input  emsm_pkg::req_t  req,
  input  logic            rsp_valid,
  input  logic            rsp_stall,
  input  emsm_pkg::rsp_t  rsp,
  output int              fail_count,
  output int              pending
);

  logic [7:0]     pat_bytes [emsm_pkg::NEEDLE_MAX];
  logic [7:0]     win_bytes [emsm_pkg::NEEDLE_MAX];
  int             pat_len;
  int             win_fill;
  logic           pat_first_at;
  logic           pat_has_at;
  logic           pat_overflow;
  logic           found;
  emsm_pkg::rsp_t expected_rsp_q [$];

  function automatic logic [7:0] lower_case(input logic [7:0] c);
    if (c >= emsm_pkg::CH_UP_A && c <= emsm_pkg::CH_UP_Z) return c + emsm_pkg::CASE_OFS;
    return c;
  endfunction

  function automatic logic address_start(input logic [7:0] c);
    logic letter, digit;
    letter = (c >= emsm_pkg::CH_LO_A) && (c <= emsm_pkg::CH_LO_Z);
    digit  = (c >= emsm_pkg::CH_0) && (c <= emsm_pkg::CH_9);
    return letter || digit || (c == emsm_pkg::CH_DOT) || (c == emsm_pkg::CH_UNDER) ||
           (c == emsm_pkg::CH_DASH);
  endfunction

  function automatic logic pattern_ok();
    return pat_has_at && !pat_first_at && !pat_overflow;
  endfunction

  function automatic void clear_search();
    foreach (win_bytes[i]) win_bytes[i] = 8'h00;
    win_fill = 0;
    found    = 1'b0;
  endfunction

  function automatic emsm_pkg::rsp_t predict_search(input emsm_pkg::req_t r);
    emsm_pkg::rsp_t res;
    logic [7:0]     c;
    logic           match;
    int             base;
    res = '0;
    c   = lower_case(r.data_byte);
    res.status = pattern_ok() ? (found ? emsm_pkg::ST_FOUND : emsm_pkg::ST_NONE) :
                                emsm_pkg::ST_INVALID;
    case (r.func)
      emsm_pkg::FUNC_CLEAR: begin
        pat_len      = 0;
        pat_first_at = 1'b0;
        pat_has_at   = 1'b0;
        pat_overflow = 1'b0;
        clear_search();
        res.status = emsm_pkg::ST_INVALID;
      end
      emsm_pkg::FUNC_APPEND: begin
        if (pat_len < emsm_pkg::NEEDLE_MAX) begin
          if (c == emsm_pkg::CH_AT) begin
            if (pat_len == 0) pat_first_at = 1'b1;
            pat_has_at = 1'b1;
          end
          pat_bytes[pat_len] = c;
          pat_len++;
        end else begin
          pat_overflow = 1'b1;
        end
        res.status = pattern_ok() ? (found ? emsm_pkg::ST_FOUND : emsm_pkg::ST_NONE) :
                                    emsm_pkg::ST_INVALID;
      end
      emsm_pkg::FUNC_HAY: begin
        for (int i = 0; i < emsm_pkg::NEEDLE_MAX - 1; i++) win_bytes[i] = win_bytes[i + 1];
        win_bytes[emsm_pkg::NEEDLE_MAX - 1] = c;
        if (win_fill < emsm_pkg::NEEDLE_MAX) win_fill++;
        res.done_res = r.last;
        if (pattern_ok()) begin
          base  = emsm_pkg::NEEDLE_MAX - pat_len;
          match = (win_fill >= pat_len) && address_start(win_bytes[base]);
          for (int i = 0; i < pat_len; i++) begin
            if (win_bytes[base + i] != pat_bytes[i]) match = 1'b0;
          end
          res.hit_now = match;
          if (match) found = 1'b1;
          res.status = found ? emsm_pkg::ST_FOUND : emsm_pkg::ST_NONE;
        end else begin
          res.status = emsm_pkg::ST_INVALID;
        end
        if (r.last) clear_search();
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch in %s: got %0d, want %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : monitor
    emsm_pkg::rsp_t want;
    if (rst) begin
      pat_len      = 0;
      pat_first_at = 1'b0;
      pat_has_at   = 1'b0;
      pat_overflow = 1'b0;
      clear_search();
      expected_rsp_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("response count (no request open)", 1, 0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.status !== want.status) report_mismatch("status", rsp.status, want.status);
          if (rsp.hit_now !== want.hit_now) report_mismatch("hit_now", rsp.hit_now, want.hit_now);
          if (rsp.done_res !== want.done_res)
            report_mismatch("done_res", rsp.done_res, want.done_res);
        end
      end
      if (req_valid && !req_stall) expected_rsp_q.push_back(predict_search(req));
    end
    pending = expected_rsp_q.size();
  end

endmodule

// ===== tb/sv/email_address_substring_matcher_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// email_address_substring_matcher_test
// Drives the address pattern matcher with directed requests (empty, invalid,
// overlong and mixed-case patterns, hits on the last byte, unused codes) and
// then with random pattern loads and haystacks under random idling on both
// channels, one long receiver hold-off and one full drain. A checker beside
// the block predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module email_address_substring_matcher_test;

  localparam emsm_pkg::func_t FUNC_UNUSED  = 2'd3;
  localparam int              RANDOM_ITEMS = 1850;
  localparam int              HOLD_CYCLES  = 300;
  localparam int              IDLE_LIMIT   = 2000;
  localparam int              DRAIN_CYCLES = 8;

  logic           clk;
  logic           rst;
  logic           req_valid;
  logic           req_stall;
  emsm_pkg::req_t req;
  logic           rsp_valid;
  logic           rsp_stall;
  emsm_pkg::rsp_t rsp;
  int             fail_count;
  int             pending;
  int             sent;
  int             idle_cycles;
  logic           burst;
  logic           hold_go;
  logic           hold_done;
  logic [7:0]     pattern_q [$];
  logic [7:0]     hay_q [$];

  email_address_substring_matcher i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  email_address_substring_matcher_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if ($urandom_range(0, 1) == 0) return c;
    if (c >= emsm_pkg::CH_LO_A && c <= emsm_pkg::CH_LO_Z) return c - emsm_pkg::CASE_OFS;
    if (c >= emsm_pkg::CH_UP_A && c <= emsm_pkg::CH_UP_Z) return c + emsm_pkg::CASE_OFS;
    return c;
  endfunction

  function automatic logic [7:0] addr_char();
    int k;
    k = $urandom_range(0, 38);
    if (k < 26) return flip_case(emsm_pkg::CH_LO_A + k[7:0]);
    if (k < 36) return emsm_pkg::CH_0 + k[7:0] - 8'd26;
    if (k == 36) return emsm_pkg::CH_DOT;
    if (k == 37) return emsm_pkg::CH_UNDER;
    return emsm_pkg::CH_DASH;
  endfunction

  task automatic send_item(input emsm_pkg::func_t f, input logic [7:0] b, input logic l);
    int gap;
    req_valid <= 1'b1;
    req       <= '{func: f, data_byte: b, last: l};
    do @(posedge clk); while (req_stall);
    if (f != FUNC_UNUSED) sent++;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic build_pattern();
    int kind, n_local, n_domain;
    pattern_q.delete();
    kind    = $urandom_range(0, 99);
    n_local = $urandom_range(1, 4);
    if (kind < 72) begin
      n_domain = $urandom_range(1, 6);
      if ($urandom_range(0, 9) == 0) n_domain = emsm_pkg::NEEDLE_MAX - 1 - n_local;
      repeat (n_local) pattern_q.push_back(addr_char());
      pattern_q.push_back(emsm_pkg::CH_AT);
      repeat (n_domain) pattern_q.push_back(addr_char());
    end else if (kind < 80) begin
      pattern_q.push_back(emsm_pkg::CH_AT);
      repeat ($urandom_range(0, 5)) pattern_q.push_back(addr_char());
    end else if (kind < 86) begin
      repeat ($urandom_range(0, 6)) pattern_q.push_back(addr_char());
    end else if (kind < 92) begin
      n_domain = emsm_pkg::NEEDLE_MAX - n_local + $urandom_range(0, 2);
      repeat (n_local) pattern_q.push_back(addr_char());
      pattern_q.push_back(emsm_pkg::CH_AT);
      repeat (n_domain) pattern_q.push_back(addr_char());
    end else if (kind < 96) begin
      pattern_q.push_back(8'($urandom_range(0, 255)));
      pattern_q.push_back(emsm_pkg::CH_AT);
      repeat ($urandom_range(1, 4)) pattern_q.push_back(addr_char());
    end else begin
      repeat ($urandom_range(1, 8)) pattern_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic build_haystack();
    int n, k, part;
    hay_q.delete();
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 30);
    while (hay_q.size() < n) begin
      k = $urandom_range(0, 99);
      if (k < 20 && pattern_q.size() > 0) begin
        foreach (pattern_q[i]) hay_q.push_back(flip_case(pattern_q[i]));
      end else if (k < 25 && pattern_q.size() > 1) begin
        part = $urandom_range(1, pattern_q.size() - 1);
        for (int i = 0; i < part; i++) hay_q.push_back(flip_case(pattern_q[i]));
      end else if (k < 70) begin
        hay_q.push_back(addr_char());
      end else begin
        hay_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic send_pattern();
    send_item(emsm_pkg::FUNC_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    foreach (pattern_q[i])
      send_item(emsm_pkg::FUNC_APPEND, pattern_q[i], 1'($urandom_range(0, 1)));
  endtask

  task automatic send_haystack();
    foreach (hay_q[i]) send_item(emsm_pkg::FUNC_HAY, hay_q[i], i == hay_q.size() - 1);
  endtask

  // receiver: random stall runs, one long hold-off on request
  initial begin : receiver
    int n;
    rsp_stall = 1'b0;
    hold_done = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_go && !hold_done) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      n = pick_gap();
      if (n > 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic pressed, paused;
    rst         = 1'b1;
    req_valid   = 1'b0;
    req         = '0;
    burst       = 1'b0;
    hold_go     = 1'b0;
    sent        = 0;
    pressed     = 1'b0;
    paused      = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty pattern, then a pattern opening with the at sign
    send_item(emsm_pkg::FUNC_HAY, "a", 1'b1);
    send_item(emsm_pkg::FUNC_APPEND, emsm_pkg::CH_AT, 1'b1);
    send_item(emsm_pkg::FUNC_APPEND, "x", 1'b0);
    send_item(emsm_pkg::FUNC_HAY, "x", 1'b0);
    send_item(emsm_pkg::FUNC_HAY, emsm_pkg::CH_AT, 1'b1);
    // mixed case pattern, found flag held to the last byte
    send_item(emsm_pkg::FUNC_CLEAR, 8'hff, 1'b1);
    send_item(emsm_pkg::FUNC_APPEND, "A", 1'b0);
    send_item(emsm_pkg::FUNC_APPEND, emsm_pkg::CH_AT, 1'b0);
    send_item(emsm_pkg::FUNC_APPEND, "b", 1'b0);
    send_item(emsm_pkg::FUNC_HAY, 8'h00, 1'b0);
    send_item(emsm_pkg::FUNC_HAY, "a", 1'b0);
    send_item(emsm_pkg::FUNC_HAY, emsm_pkg::CH_AT, 1'b0);
    send_item(emsm_pkg::FUNC_HAY, "B", 1'b0);
    send_item(FUNC_UNUSED, 8'hff, 1'b1);
    send_item(emsm_pkg::FUNC_HAY, 8'hff, 1'b1);
    // hit on the closing byte
    send_item(emsm_pkg::FUNC_HAY, "a", 1'b0);
    send_item(emsm_pkg::FUNC_HAY, emsm_pkg::CH_AT, 1'b0);
    send_item(emsm_pkg::FUNC_HAY, "b", 1'b1);
    // first byte outside the address set never hits
    send_item(emsm_pkg::FUNC_CLEAR, 8'h00, 1'b0);
    send_item(emsm_pkg::FUNC_APPEND, "!", 1'b0);
    send_item(emsm_pkg::FUNC_APPEND, emsm_pkg::CH_AT, 1'b0);
    send_item(emsm_pkg::FUNC_HAY, "!", 1'b0);
    send_item(emsm_pkg::FUNC_HAY, emsm_pkg::CH_AT, 1'b1);
    // overlong pattern
    send_item(emsm_pkg::FUNC_CLEAR, 8'h00, 1'b0);
    send_item(emsm_pkg::FUNC_APPEND, "a", 1'b0);
    send_item(emsm_pkg::FUNC_APPEND, emsm_pkg::CH_AT, 1'b0);
    repeat (emsm_pkg::NEEDLE_MAX - 1) send_item(emsm_pkg::FUNC_APPEND, "z", 1'b0);
    send_item(emsm_pkg::FUNC_HAY, "z", 1'b1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 9) == 0);
      if (!pressed && sent > RANDOM_ITEMS / 3) begin
        pressed = 1'b1;
        hold_go <= 1'b1;
        burst   = 1'b1;
        build_pattern();
        send_pattern();
        hay_q.delete();
        repeat (200) hay_q.push_back(addr_char());
        foreach (pattern_q[i]) hay_q.push_back(pattern_q[i]);
        send_haystack();
      end else if (!paused && sent > 2 * RANDOM_ITEMS / 3) begin
        paused = 1'b1;
        wait_drained();
      end else if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4))
          send_item(emsm_pkg::func_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
      end else begin
        build_pattern();
        send_pattern();
        repeat ($urandom_range(1, 3)) begin
          build_haystack();
          send_haystack();
        end
      end
    end
    burst = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
